/* design/swr_pkg.sv */
// package: shared types and codes of the stack with remove-by-value
package swr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CAP_W     = 5;
  localparam int POS_W     = 4;
  localparam int CNT_W     = 5;
  localparam int WORD_W    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SWAP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] item_value;
    logic [POS_W-1:0]         position;
    logic [CNT_W-1:0]         count;
  } res_t;

  // classified request as it waits between front and back
  typedef struct packed {
    op_t                      op;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

endpackage

/* design/swr_ram.sv */
// generic single-write, single-read ram with registered read data
module swr_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/swr_front.sv */
// front end: accepts request beats, classifies them and queues two deep
module swr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  swr_pkg::req_t in_data,
  output logic          q_valid,
  output swr_pkg::cmd_t q_data,
  input  logic          q_take
);
  import swr_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc;
  cmd_t       cls;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = slot_r[rd_ptr_r];
  assign acc     = push && !full;

  always_comb begin
    cls.op    = op_t'(in_data.op);
    cls.value = in_data.value;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (acc) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (q_take) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (acc && !q_take) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!acc && q_take) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* design/swr_back.sv */
// back end: sequencer that carries out stack operations on the entry ram
module swr_back #(
  parameter int DEPTH = swr_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [swr_pkg::CAP_W-1:0] cap,
  input  logic                      q_valid,
  input  swr_pkg::cmd_t             q_data,
  output logic                      q_take,
  output logic                      empty,
  input  logic                      pop,
  output swr_pkg::res_t             out_data
);
  import swr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int MW = (FW > CAP_W) ? FW : CAP_W;
  localparam int PW = (AW > POS_W) ? AW : POS_W;
  localparam int NW = (FW > CNT_W) ? FW : CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SW1,
    S_SW2,
    S_SW3
  } state_t;

  state_t                   state_r, state_nxt;
  logic [FW-1:0]            fill_r, fill_nxt;
  logic                     res_v_r, res_v_nxt;
  res_t                     res_r, res_nxt;
  logic signed [WORD_W-1:0] key_r, key_nxt;
  logic [AW-1:0]            dat_idx_r, dat_idx_nxt;
  logic                     found_r, found_nxt;
  logic [AW-1:0]            hit_r, hit_nxt;
  logic [AW-1:0]            top_r, top_nxt;
  logic [WORD_W-1:0]        tmp_r, tmp_nxt;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [WORD_W-1:0]        wdata;
  logic [AW-1:0]            raddr;
  logic [WORD_W-1:0]        rdata;

  logic [FW-1:0]            fill_m1;
  logic [AW-1:0]            top_a;
  logic                     is_empty;
  logic                     is_full;
  logic                     match;
  logic                     last;

  function automatic res_t mk_res(status_t st, logic [WORD_W-1:0] v,
                                  logic [AW-1:0] p, logic [FW-1:0] c);
    res_t          r;
    logic [PW-1:0] pw;
    logic [NW-1:0] cw;
    pw           = PW'(p);
    cw           = NW'(c);
    r.status     = st;
    r.item_value = v;
    r.position   = pw[POS_W-1:0];
    r.count      = cw[CNT_W-1:0];
    return r;
  endfunction

  swr_ram #(
    .W (WORD_W),
    .D (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign empty    = !res_v_r;
  assign out_data = res_r;

  assign fill_m1  = fill_r - 1'b1;
  assign top_a    = fill_m1[AW-1:0];
  assign is_empty = (fill_r == '0);
  assign is_full  = (MW'(fill_r) >= MW'(cap)) || (fill_r == FW'(DEPTH));
  assign match    = (rdata == key_r);
  assign last     = (dat_idx_r == top_a);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    res_v_nxt   = res_v_r;
    res_nxt     = res_r;
    key_nxt     = key_r;
    dat_idx_nxt = dat_idx_r;
    found_nxt   = found_r;
    hit_nxt     = hit_r;
    top_nxt     = top_r;
    tmp_nxt     = tmp_r;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    q_take      = 1'b0;

    if (pop && res_v_r) begin
      res_v_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid && !res_v_r) begin
          q_take = 1'b1;
          case (q_data.op)
            OP_PUSH: begin
              res_v_nxt = 1'b1;
              if (is_full) begin
                res_nxt = mk_res(ST_FULL, q_data.value, '0, fill_r);
              end else begin
                we       = 1'b1;
                waddr    = fill_r[AW-1:0];
                wdata    = q_data.value;
                fill_nxt = fill_r + 1'b1;
                res_nxt  = mk_res(ST_DONE, q_data.value, fill_r[AW-1:0],
                                  fill_r + 1'b1);
              end
            end
            OP_POP: begin
              if (is_empty) begin
                res_v_nxt = 1'b1;
                res_nxt   = mk_res(ST_EMPTY, '0, '0, fill_r);
              end else begin
                raddr     = top_a;
                top_nxt   = top_a;
                fill_nxt  = fill_m1;
                state_nxt = S_POP;
              end
            end
            OP_REMOVE: begin
              if (is_empty) begin
                res_v_nxt = 1'b1;
                res_nxt   = mk_res(ST_EMPTY, '0, '0, fill_r);
              end else begin
                key_nxt     = q_data.value;
                raddr       = '0;
                dat_idx_nxt = '0;
                found_nxt   = 1'b0;
                state_nxt   = S_SCAN;
              end
            end
            OP_SWAP: begin
              if (is_empty) begin
                res_v_nxt = 1'b1;
                res_nxt   = mk_res(ST_EMPTY, '0, '0, fill_r);
              end else begin
                raddr     = '0;
                top_nxt   = top_a;
                state_nxt = S_SW1;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_POP: begin
        res_v_nxt = 1'b1;
        res_nxt   = mk_res(ST_DONE, rdata, top_r, fill_r);
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        // entries above the hit move down one place as they stream past
        if (found_r) begin
          we    = 1'b1;
          waddr = dat_idx_r - 1'b1;
          wdata = rdata;
        end
        if (!found_r && match) begin
          found_nxt = 1'b1;
          hit_nxt   = dat_idx_r;
        end
        if (last) begin
          res_v_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (found_r || match) begin
            fill_nxt = fill_m1;
            res_nxt  = mk_res(ST_DONE, key_r, found_r ? hit_r : dat_idx_r, fill_m1);
          end else begin
            res_nxt  = mk_res(ST_NOTFOUND, key_r, '0, fill_r);
          end
        end else begin
          raddr       = dat_idx_r + 1'b1;
          dat_idx_nxt = dat_idx_r + 1'b1;
        end
      end
      S_SW1: begin
        tmp_nxt   = rdata;
        raddr     = top_r;
        state_nxt = S_SW2;
      end
      S_SW2: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = rdata;
        state_nxt = S_SW3;
      end
      S_SW3: begin
        we        = 1'b1;
        waddr     = top_r;
        wdata     = tmp_r;
        res_v_nxt = 1'b1;
        res_nxt   = mk_res(ST_DONE, tmp_r, top_r, fill_r);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      res_v_r <= res_v_nxt;
    end
    res_r     <= res_nxt;
    key_r     <= key_nxt;
    dat_idx_r <= dat_idx_nxt;
    found_r   <= found_nxt;
    hit_r     <= hit_nxt;
    top_r     <= top_nxt;
    tmp_r     <= tmp_nxt;
  end

endmodule

/* design/stack_with_remove_by_value_top.sv */
// top level: bounded lifo stack of signed words with remove-by-value
//
// a bounded lifo stack of signed 32-bit words held in a single-port-write,
// single-port-read ram of DEPTH entries. requests (push, pop, remove the
// matching entry nearest the bottom, swap bottom and top) enter through a
// two-deep request queue and are carried out one at a time by a sequencer;
// each request gives exactly one result beat with status, word, position and
// new count. the usable capacity is min(cfg_data, DEPTH), written whenever
// cfg_we is high. a remove does one ram read per held entry, as the single
// read port streams the entries past the comparator and the write port moves
// those above the hit down one place. a new request starts in the cycle after
// the previous result beat has been popped. the entry ram needs no clearing
// after reset: only entries below the fill count are ever read.
module stack_with_remove_by_value_top #(
  parameter int DEPTH = swr_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      push,
  output logic                      full,
  input  swr_pkg::req_t             in_data,
  // result channel
  output logic                      empty,
  input  logic                      pop,
  output swr_pkg::res_t             out_data,
  // capacity register
  input  logic                      cfg_we,
  input  logic [swr_pkg::CAP_W-1:0] cfg_data
);
  import swr_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             q_valid;
  cmd_t             q_data;
  logic             q_take;

  // capacity register, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_data;
    end
  end

  // front: takes request beats and decodes the op while the back is busy
  swr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_take  (q_take)
  );

  // back: sequencer, entry ram and result register
  swr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cap      (cap_r),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_take   (q_take),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // the back never takes a request from an empty queue
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid)
    else $error("request taken from empty queue");

  // a request is taken only while no result waits
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> empty)
    else $error("request taken while a result beat waits");

  // empty refusals report a zero word, zero position and zero count
  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status == ST_EMPTY) |->
      (out_data.item_value == 0 && out_data.position == 0 && out_data.count == 0))
    else $error("empty refusal with nonzero fields");

  // a failed search leaves position at zero
  a_nf_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status == ST_NOTFOUND) |-> (out_data.position == 0))
    else $error("not-found result with nonzero position");
`endif

endmodule

/* verif/tb_top.sv */
// testbench for the lifo stack with remove-by-value: self-checking, random and directed
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swr_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int IDLE_LIMIT = 2000;  // cycles with no beat on either side
  localparam int TAIL_WAIT  = 24;    // longest remove plus queue, with margin

  // scoreboard: shadow stack, capacity copy and the queue of predicted results
  class lifo_checker;
    logic signed [WORD_W-1:0] held_words [DEPTH];
    int   held_count;
    int   capacity;
    res_t pending_results [$];
    int   errors;
    int   checked;
    int   status_hits [4];

    function new();
      held_count = 0;
      capacity   = CAP_RESET;
      errors     = 0;
      checked    = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // work out the result of one accepted request and queue it
    function void take_request(req_t r);
      res_t e;
      int   lim;
      int   hit;
      int   top;
      logic signed [WORD_W-1:0] t;
      lim = (capacity < DEPTH) ? capacity : DEPTH;
      e.status     = ST_DONE;
      e.item_value = '0;
      e.position   = '0;
      case (op_t'(r.op))
        OP_PUSH: begin
          e.item_value = r.value;
          if (held_count >= lim) begin
            e.status = ST_FULL;
          end else begin
            held_words[held_count] = r.value;
            e.position = held_count[POS_W-1:0];
            held_count++;
          end
        end
        OP_POP: begin
          if (held_count == 0) begin
            e.status = ST_EMPTY;
          end else begin
            held_count--;
            e.item_value = held_words[held_count];
            e.position   = held_count[POS_W-1:0];
          end
        end
        OP_REMOVE: begin
          if (held_count == 0) begin
            e.status = ST_EMPTY;
          end else begin
            hit = -1;
            for (int i = 0; i < held_count; i++)
              if (hit < 0 && held_words[i] == r.value) hit = i;
            e.item_value = r.value;
            if (hit < 0) begin
              e.status = ST_NOTFOUND;
            end else begin
              for (int i = hit; i + 1 < held_count; i++) held_words[i] = held_words[i+1];
              held_count--;
              e.position = hit[POS_W-1:0];
            end
          end
        end
        default: begin
          if (held_count == 0) begin
            e.status = ST_EMPTY;
          end else begin
            top = held_count - 1;
            t = held_words[0];
            held_words[0]   = held_words[top];
            held_words[top] = t;
            e.item_value = held_words[top];
            e.position   = top[POS_W-1:0];
          end
        end
      endcase
      e.count = held_count[CNT_W-1:0];
      pending_results.push_back(e);
    endfunction

    function void field_diff(string f, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, f, exp_v, got_v);
        errors++;
      end
    endfunction

    // compare one popped result beat with the oldest prediction
    function void check_result(res_t got);
      res_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing predicted, actual %0h", $time, got);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      checked++;
      status_hits[e.status]++;
      field_diff("status", e.status, got.status);
      field_diff("item_value", e.item_value, got.item_value);
      field_diff("position", e.position, got.position);
      field_diff("count", e.count, got.count);
    endfunction
  endclass

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                push     = 1'b0;
  logic                full;
  req_t                in_data  = '0;
  logic                empty;
  logic                pop      = 1'b0;
  res_t                out_data;
  logic                cfg_we   = 1'b0;
  logic [CAP_W-1:0]    cfg_data = '0;

  lifo_checker sb;
  bit calm = 1'b0;        // set during the stretch with no idling on either side
  int requests_sent = 0;
  int caps_written  = 0;
  int idle_cycles   = 0;

  always #1 clk = ~clk;

  stack_with_remove_by_value_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // result side: values read here are the ones from just before the edge,
  // so a beat is taken exactly when the block sees pop high and empty low
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(out_data);
    pop <= calm ? 1'b1 : ($urandom_range(99) >= 12);
  end

  // watchdog: any beat on either side resets the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, sb.pending_results.size());
        $display("stack_with_remove_by_value_top test failed");
        $finish;
      end
    end
  end

  function automatic req_t req(op_t op, logic signed [WORD_W-1:0] value);
    req_t r;
    r.op    = op;
    r.value = value;
    return r;
  endfunction

  // words drawn mostly from a tiny pool so that removes find duplicates,
  // with the extremes and fully random words mixed in
  function automatic logic signed [WORD_W-1:0] pick_word();
    int k;
    k = $urandom_range(99);
    if (k < 45) return int'($urandom_range(6)) - 3;
    if (k < 55) begin
      case ($urandom_range(3))
        0:       return 32'sh7fff_ffff;
        1:       return 32'sh8000_0000;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  // one random request; weights in percent, the rest are swaps
  function automatic req_t make_request(int push_w, int pop_w, int rem_w);
    int k;
    k = $urandom_range(99);
    if (k < push_w) return req(OP_PUSH, pick_word());
    if (k < push_w + pop_w) return req(OP_POP, $urandom());
    if (k < push_w + pop_w + rem_w) begin
      // mostly search for a word that is held, so the shift path gets exercised
      if (sb.held_count > 0 && $urandom_range(99) < 65)
        return req(OP_REMOVE, sb.held_words[$urandom_range(sb.held_count - 1)]);
      return req(OP_REMOVE, pick_word());
    end
    return req(OP_SWAP, $urandom());
  endfunction

  // request side: push stays high after a beat so back-to-back beats are
  // possible; a random gap lowers it first
  task automatic send_request(req_t r);
    if (!calm)
      while ($urandom_range(99) < 12) begin
        push <= 1'b0;
        @(posedge clk);
      end
    push    <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (full);
    sb.take_request(r);
    requests_sent++;
  endtask

  // capacity is only changed with the block idle: drain, let it settle, write
  task automatic set_capacity(logic [CAP_W-1:0] c);
    push <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.capacity = c;
    caps_written++;
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [10] = '{16, 31, 4, 1, 9, 16, 2, 31, 7, 13};
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: refusals on an empty stack, extremes, zero words, a
    // duplicate zero, a miss, swap with one and with several entries
    set_capacity(16);
    send_request(req(OP_POP, 0));
    send_request(req(OP_REMOVE, 7));
    send_request(req(OP_SWAP, 0));
    send_request(req(OP_PUSH, 32'sh7fff_ffff));
    send_request(req(OP_SWAP, 0));
    send_request(req(OP_PUSH, 32'sh8000_0000));
    send_request(req(OP_PUSH, 0));
    send_request(req(OP_PUSH, -1));
    send_request(req(OP_PUSH, 0));
    send_request(req(OP_REMOVE, 0));
    send_request(req(OP_REMOVE, 123));
    send_request(req(OP_SWAP, 0));
    send_request(req(OP_POP, 0));

    // zero capacity refuses every push
    set_capacity(0);
    send_request(req(OP_PUSH, 1));
    send_request(req(OP_POP, 0));

    // capacity below the fill count: pushes refused until pops make room
    set_capacity(1);
    send_request(req(OP_PUSH, 5));
    send_request(req(OP_POP, 0));
    send_request(req(OP_POP, 0));
    send_request(req(OP_PUSH, 5));
    send_request(req(OP_PUSH, 6));
    send_request(req(OP_REMOVE, 5));

    // random phases, alternating between filling and draining the stack;
    // the sixth phase runs with no idling at all
    foreach (phase_caps[p]) begin
      set_capacity(phase_caps[p]);
      calm = (p == 5);
      for (int n = 0; n < 183; n++) begin
        if (p % 2 == 0) send_request(make_request(55, 15, 20));
        else            send_request(make_request(30, 35, 25));
      end
    end
    calm = 1'b0;
    push <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d requests over %0d capacity writes, %0d results checked",
             requests_sent, caps_written, sb.checked);
    $display("results by status: done %0d, full %0d, empty %0d, not found %0d",
             sb.status_hits[ST_DONE], sb.status_hits[ST_FULL],
             sb.status_hits[ST_EMPTY], sb.status_hits[ST_NOTFOUND]);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("stack_with_remove_by_value_top test passed");
    end else begin
      $display("stack_with_remove_by_value_top test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/swr_pkg.sv
design/swr_ram.sv
design/swr_front.sv
design/swr_back.sv
design/stack_with_remove_by_value_top.sv
verif/tb_top.sv
